@@ rtl/color_temperature_to_rgb_defines.svh @@
// Assertion macros shared by the color temperature to RGB block.
`ifndef COLOR_TEMPERATURE_TO_RGB_DEFINES_SVH
`define COLOR_TEMPERATURE_TO_RGB_DEFINES_SVH

// expression must hold at every clock edge outside reset
`define CTR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CTR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ctr_pkg.sv @@
// Types, constants and the knot ROM of the color temperature to RGB block.
package ctr_pkg;
	localparam int KNOT_COUNT = 22;
	localparam int SEG_COUNT = KNOT_COUNT - 4;
	localparam int OUT_FRAC_BITS_DEF = 13;
	localparam int TEMP_W = 16;
	localparam int OUT_W = 16;
	localparam int KNOT_W = 17;
	localparam int KNOT_FRAC = 16;
	localparam int FRAC_W = 16;
	localparam int COEF_W = 24;
	localparam int PROD_W = COEF_W + FRAC_W + 1;
	localparam int LUMA_W = 41;
	localparam int SEG_W = 5;
	localparam int REM_W = 14;
	localparam int X_W = 18;
	localparam int NUM_W = REM_W + FRAC_W;
	localparam int RECIP_W = 31;
	localparam int RECIP_SHIFT = 44;

	localparam logic [TEMP_W-1:0] TEMP_LOW = 16'd1000;
	localparam logic [TEMP_W-1:0] TEMP_HIGH = 16'd10000;
	localparam logic [X_W-1:0] TEMP_SPAN = 18'd9000;
	localparam logic [NUM_W-1:0] SPAN_HALF = 30'd4500;
	// ceil(2^44 / 9000): exact floor division for numerators below 2^30
	localparam logic [RECIP_W-1:0] SPAN_RECIP = 31'd1954687339;

	localparam logic signed [16:0] LUMA_R = 17'sd13933;
	localparam logic signed [16:0] LUMA_G = 17'sd46871;
	localparam logic signed [16:0] LUMA_B = 17'sd4732;

	typedef logic [KNOT_W-1:0] knot_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		coef_t a;
		coef_t b;
		coef_t c;
		coef_t d;
	} cubic_t;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} rgb_t;

	localparam knot_t KNOT_ROM [KNOT_COUNT][3] = '{
		'{17'd65536, 17'd1802,  17'd0},
		'{17'd65536, 17'd1802,  17'd0},
		'{17'd65536, 17'd9808,  17'd0},
		'{17'd65536, 17'd16819, 17'd531},
		'{17'd65536, 17'd24382, 17'd4420},
		'{17'd65536, 17'd31243, 17'd10066},
		'{17'd65536, 17'd37380, 17'd16987},
		'{17'd65536, 17'd42826, 17'd24717},
		'{17'd65536, 17'd47637, 17'd32873},
		'{17'd65536, 17'd51875, 17'd41160},
		'{17'd65536, 17'd55605, 17'd49364},
		'{17'd65536, 17'd58889, 17'd57338},
		'{17'd65536, 17'd61785, 17'd64988},
		'{17'd59438, 17'd58357, 17'd65536},
		'{17'd54280, 17'd55171, 17'd65536},
		'{17'd50187, 17'd52553, 17'd65536},
		'{17'd46875, 17'd50370, 17'd65536},
		'{17'd44150, 17'd48524, 17'd65536},
		'{17'd41877, 17'd46947, 17'd65536},
		'{17'd39956, 17'd45586, 17'd65536},
		'{17'd39956, 17'd45586, 17'd65536},
		'{17'd39956, 17'd45586, 17'd65536}
	};

	// floor((p + 2^15) / 2^16)
	function automatic coef_t rnd16(prod_t p);
		prod_t t;
		t = p + PROD_W'(32768);
		rnd16 = coef_t'(t >>> 16);
	endfunction

	function automatic coef_t knot_ext(knot_t k);
		knot_ext = coef_t'({1'b0, k});
	endfunction
endpackage

@@ rtl/ctr_front.sv @@
// Front end: clamp, segment and fraction, knot fetch and cubic coefficients.
module ctr_front
	import ctr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic [TEMP_W-1:0]    temperature_k,
	output logic                 vld_o,
	output logic [FRAC_W-1:0]    frac,
	output cubic_t               cubic [3]
);
	logic [TEMP_W-1:0] t_cl;
	logic [REM_W-1:0] ofs;
	logic [X_W-1:0] x_s1;
	logic [SEG_W-1:0] seg_c;
	logic [X_W-1:0] seg_base;
	logic [SEG_W-1:0] seg_s2, seg_s3;
	logic [REM_W-1:0] rem_s2;
	logic [NUM_W-1:0] num;
	logic [NUM_W+RECIP_W-1:0] prod;
	logic [FRAC_W-1:0] frac_s3, frac_s4;
	cubic_t cub_s4 [3];
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	always_comb begin
		if (temperature_k < TEMP_LOW) t_cl = TEMP_LOW;
		else if (temperature_k > TEMP_HIGH) t_cl = TEMP_HIGH;
		else t_cl = temperature_k;
		ofs = REM_W'(t_cl - TEMP_LOW);
	end

	// segment = x / 9000, x below 19 * 9000
	always_comb begin
		seg_c = '0;
		for (int k = 1; k <= SEG_COUNT; k++) begin
			if (x_s1 >= X_W'(k * 9000)) seg_c = SEG_W'(k);
		end
		seg_base = X_W'(seg_c * TEMP_SPAN);
	end

	always_comb begin
		num = {rem_s2, {FRAC_W{1'b0}}} + SPAN_HALF;
		prod = num * SPAN_RECIP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= ({4'b0, ofs} << 4) + ({4'b0, ofs} << 1);
			seg_s2 <= seg_c;
			rem_s2 <= REM_W'(x_s1 - seg_base);
			seg_s3 <= seg_s2;
			frac_s3 <= prod[RECIP_SHIFT+FRAC_W-1:RECIP_SHIFT];
			frac_s4 <= frac_s3;
			for (int c = 0; c < 3; c++) begin
				cub_s4[c].a <= knot_ext(KNOT_ROM[seg_s3+3][c])
					- knot_ext(KNOT_ROM[seg_s3][c])
					+ knot_ext(KNOT_ROM[seg_s3+1][c]) + knot_ext(KNOT_ROM[seg_s3+1][c])
					+ knot_ext(KNOT_ROM[seg_s3+1][c])
					- knot_ext(KNOT_ROM[seg_s3+2][c]) - knot_ext(KNOT_ROM[seg_s3+2][c])
					- knot_ext(KNOT_ROM[seg_s3+2][c]);
				cub_s4[c].b <= (knot_ext(KNOT_ROM[seg_s3][c]) <<< 1)
					- (knot_ext(KNOT_ROM[seg_s3+1][c]) <<< 2)
					- knot_ext(KNOT_ROM[seg_s3+1][c])
					+ (knot_ext(KNOT_ROM[seg_s3+2][c]) <<< 2)
					- knot_ext(KNOT_ROM[seg_s3+3][c]);
				cub_s4[c].c <= knot_ext(KNOT_ROM[seg_s3+2][c]) - knot_ext(KNOT_ROM[seg_s3][c]);
				cub_s4[c].d <= knot_ext(KNOT_ROM[seg_s3+1][c]) <<< 1;
			end
		end
	end

	assign vld_o = vld_s4;
	assign frac = frac_s4;
	assign cubic = cub_s4;
endmodule

@@ rtl/ctr_spline.sv @@
// Horner evaluation of the three channel cubics, multiply and round in turn.
module ctr_spline
	import ctr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld,
	input  logic [FRAC_W-1:0] frac,
	input  cubic_t            cubic [3],
	output logic              vld_o,
	output coef_t             h [3]
);
	logic [5:0] vld_s;
	logic [FRAC_W-1:0] f_s1, f_s2, f_s3, f_s4;
	cubic_t cub_s1 [3], cub_s2 [3], cub_s3 [3], cub_s4 [3], cub_s5 [3];
	prod_t p_s1 [3], p_s3 [3], p_s5 [3];
	coef_t v_s2 [3], v_s4 [3], v_s6 [3];
	logic signed [FRAC_W:0] fs0, fs2, fs4;

	assign fs0 = $signed({1'b0, frac});
	assign fs2 = $signed({1'b0, f_s2});
	assign fs4 = $signed({1'b0, f_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[4:0], vld};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= frac;
			f_s2 <= f_s1;
			f_s3 <= f_s2;
			f_s4 <= f_s3;
			for (int c = 0; c < 3; c++) begin
				cub_s1[c] <= cubic[c];
				cub_s2[c] <= cub_s1[c];
				cub_s3[c] <= cub_s2[c];
				cub_s4[c] <= cub_s3[c];
				cub_s5[c] <= cub_s4[c];
				p_s1[c] <= cubic[c].a * fs0;
				v_s2[c] <= rnd16(p_s1[c]) + cub_s1[c].b;
				p_s3[c] <= v_s2[c] * fs2;
				v_s4[c] <= rnd16(p_s3[c]) + cub_s3[c].c;
				p_s5[c] <= v_s4[c] * fs4;
				v_s6[c] <= rnd16(p_s5[c]) + cub_s5[c].d;
			end
		end
	end

	assign vld_o = vld_s[5];
	assign h = v_s6;
endmodule

@@ rtl/ctr_norm.sv @@
// Luma, then per channel rounded division by luma with saturation, one bit a stage.
module ctr_norm
	import ctr_pkg::*;
#(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld,
	input  coef_t h [3],
	output logic  vld_o,
	output rgb_t  rgb
);
	localparam int DW = LUMA_W + KNOT_FRAC + OUT_FRAC_BITS;
	localparam int LU_W = LUMA_W - 1;

	logic vld_s1, vld_s2;
	logic signed [LUMA_W-1:0] lp_s1 [3];
	coef_t h_s1 [3];
	logic signed [LUMA_W-1:0] luma;
	logic [DW-1:0] num [3];
	logic [LU_W-1:0] lum_s2;
	logic [DW-1:0] n_s2 [3];
	logic zero_s2 [3];

	// division pipeline, index 0 is the saturation check
	logic vld_d [OUT_W+1];
	logic [LU_W-1:0] lum_d [OUT_W+1];
	logic [DW-1:0] rem_d [OUT_W+1][3];
	logic [OUT_W-1:0] quo_d [OUT_W+1][3];
	logic zero_d [OUT_W+1][3];
	logic sat_d [OUT_W+1][3];

	always_comb begin
		luma = lp_s1[0] + lp_s1[1] + lp_s1[2];
		for (int c = 0; c < 3; c++) begin
			num[c] = ((!h_s1[c][COEF_W-1] && h_s1[c] != '0)
				? (DW'(h_s1[c][COEF_W-2:0]) << (KNOT_FRAC + OUT_FRAC_BITS)) : '0)
				+ DW'(luma[LU_W-1:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_d[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lp_s1[0] <= h[0] * LUMA_R;
			lp_s1[1] <= h[1] * LUMA_G;
			lp_s1[2] <= h[2] * LUMA_B;
			lum_s2 <= luma[LU_W-1:0];
			lum_d[0] <= lum_s2;
			for (int c = 0; c < 3; c++) begin
				h_s1[c] <= h[c];
				n_s2[c] <= num[c];
				// luma not positive, or channel not positive
				zero_s2[c] <= luma[LUMA_W-1] || luma == '0 || h_s1[c][COEF_W-1]
					|| h_s1[c] == '0;
				rem_d[0][c] <= n_s2[c];
				quo_d[0][c] <= '0;
				zero_d[0][c] <= zero_s2[c];
				sat_d[0][c] <= n_s2[c] >= (DW'(lum_s2) << OUT_W);
			end
		end
	end

	for (genvar k = 0; k < OUT_W; k++) begin : g_div
		localparam int BIT = OUT_W - 1 - k;
		logic [DW-1:0] dv;
		logic cmp [3];

		assign dv = DW'(lum_d[k]) << BIT;
		always_comb begin
			for (int c = 0; c < 3; c++) cmp[c] = rem_d[k][c] >= dv;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[k+1] <= 1'b0;
			else if (en) vld_d[k+1] <= vld_d[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lum_d[k+1] <= lum_d[k];
				for (int c = 0; c < 3; c++) begin
					rem_d[k+1][c] <= cmp[c] ? rem_d[k][c] - dv : rem_d[k][c];
					quo_d[k+1][c] <= quo_d[k][c] | (cmp[c] ? OUT_W'(1) << BIT : '0);
					zero_d[k+1][c] <= zero_d[k][c];
					sat_d[k+1][c] <= sat_d[k][c];
				end
			end
		end
	end

	function automatic logic [OUT_W-1:0] pick(logic z, logic s, logic [OUT_W-1:0] q);
		pick = z ? '0 : (s ? '1 : q);
	endfunction

	assign vld_o = vld_d[OUT_W];
	assign rgb.red = pick(zero_d[OUT_W][0], sat_d[OUT_W][0], quo_d[OUT_W][0]);
	assign rgb.green = pick(zero_d[OUT_W][1], sat_d[OUT_W][1], quo_d[OUT_W][1]);
	assign rgb.blue = pick(zero_d[OUT_W][2], sat_d[OUT_W][2], quo_d[OUT_W][2]);
endmodule

@@ rtl/color_temperature_to_rgb.sv @@
// Top level: color temperature to luma-normalized RGB, pipeline and output buffer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  temp     | temp_valid, temp_stall | temperature_k
//  rgb      | rgb_valid, rgb_stall   | red, green, blue
//
// One beat enters per cycle while temp_stall is low. The divider (17 stages,
// its saturation check and the per-bit stages) sets most of the pipeline depth.
// Reset clears all valid bits and the buffer count; no clearing pass.
// A two-entry output buffer lets the pipeline keep moving while a result is
// stalled; the pipeline freezes only when both entries are full.
module color_temperature_to_rgb
	import ctr_pkg::*;
#(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              temp_valid,
	output logic              temp_stall,
	input  logic [TEMP_W-1:0] temperature_k,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output logic [OUT_W-1:0]  red,
	output logic [OUT_W-1:0]  green,
	output logic [OUT_W-1:0]  blue
);
	`include "color_temperature_to_rgb_defines.svh"

	logic en;
	logic f_vld, s_vld, n_vld;
	logic [FRAC_W-1:0] frac;
	cubic_t cubic [3];
	coef_t h [3];
	rgb_t pipe_rgb;
	rgb_t head_q, tail_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign en = cnt_q != 2'd2;
	assign temp_stall = !en;
	assign push = n_vld && en;
	assign pop = cnt_q != 2'd0 && !rgb_stall;

	ctr_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(temp_valid && en),
		.temperature_k(temperature_k), .vld_o(f_vld), .frac(frac), .cubic(cubic)
	);

	ctr_spline u_horner (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(f_vld),
		.frac(frac), .cubic(cubic), .vld_o(s_vld), .h(h)
	);

	ctr_norm #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(s_vld),
		.h(h), .vld_o(n_vld), .rgb(pipe_rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else if (push && !pop) cnt_q <= cnt_q + 2'd1;
		else if (pop && !push) cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) head_q <= pipe_rgb;
			else begin
				head_q <= tail_q;
				tail_q <= pipe_rgb;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) head_q <= pipe_rgb;
			else tail_q <= pipe_rgb;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	assign rgb_valid = cnt_q != 2'd0;
	assign red = head_q.red;
	assign green = head_q.green;
	assign blue = head_q.blue;

	`CTR_ASSERT(a_cnt_range, cnt_q != 2'd3, "output buffer count out of range")
	`CTR_ASSERT_NEXT(a_cnt_drop, pop && !push, cnt_q == $past(cnt_q) - 2'd1,
		"pop without push did not drop the count")
	`CTR_ASSERT_NEXT(a_head_fill, push && cnt_q == 2'd0, head_q == $past(pipe_rgb),
		"beat into empty buffer not at head")
endmodule

@@ tb/tb_top.sv @@
// Testbench for the color temperature to RGB block: directed and random beats vs. a local model.
`timescale 1ns / 100ps

module tb_top;
	import ctr_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              temp_valid = 1'b0;
	logic              temp_stall;
	logic [TEMP_W-1:0] temperature_k = '0;
	logic              rgb_valid;
	logic              rgb_stall = 1'b0;
	logic [OUT_W-1:0]  red;
	logic [OUT_W-1:0]  green;
	logic [OUT_W-1:0]  blue;

	rgb_t expected_rgb[$];
	int   mismatch_count = 0;
	int   unexpected_count = 0;
	int   beats_sent = 0;
	int   beats_checked = 0;
	int   hold_off_cycles = 0;
	int   sink_idle = 0;
	bit   sink_gaps_on = 1'b1;

	always #4 clk = ~clk;

	color_temperature_to_rgb u_top (
		.clk(clk), .arst_n(arst_n),
		.temp_valid(temp_valid), .temp_stall(temp_stall), .temperature_k(temperature_k),
		.rgb_valid(rgb_valid), .rgb_stall(rgb_stall),
		.red(red), .green(green), .blue(blue)
	);

	// floor((v + 2^15) / 2^16)
	function automatic longint half_up16(longint v);
		longint t;
		t = v + 64'sd32768;
		half_up16 = t >>> 16;
	endfunction

	function automatic logic [OUT_W-1:0] luma_scale(longint h, longint luma);
		longint unsigned num, q;
		if (h <= 0) return '0;
		num = longint'(h) << (16 + OUT_FRAC_BITS_DEF);
		q = (num + longint'(luma) / 2) / longint'(luma);
		return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic rgb_t blackbody_rgb(logic [TEMP_W-1:0] tk);
		longint t, x, seg, f, k0, k1, k2, k3, a, b, cc, d, v, luma;
		longint h[3];
		rgb_t r;
		t = tk;
		if (t < 1000) t = 1000;
		if (t > 10000) t = 10000;
		x = (t - 1000) * SEG_COUNT;
		seg = x / 9000;
		f = (((x % 9000) << 16) + 4500) / 9000;
		if (seg > SEG_COUNT) seg = SEG_COUNT;
		for (int c = 0; c < 3; c++) begin
			k0 = KNOT_ROM[seg][c];
			k1 = KNOT_ROM[seg+1][c];
			k2 = KNOT_ROM[seg+2][c];
			k3 = KNOT_ROM[seg+3][c];
			a = -k0 + 3*k1 - 3*k2 + k3;
			b = 2*k0 - 5*k1 + 4*k2 - k3;
			cc = k2 - k0;
			d = 2*k1;
			v = a;
			v = half_up16(v * f) + b;
			v = half_up16(v * f) + cc;
			v = half_up16(v * f) + d;
			h[c] = v;
		end
		luma = 13933*h[0] + 46871*h[1] + 4732*h[2];
		if (luma <= 0) return '0;
		r.red = luma_scale(h[0], luma);
		r.green = luma_scale(h[1], luma);
		r.blue = luma_scale(h[2], luma);
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
	endfunction

	// one beat on the temperature channel, with an optional random gap first
	task automatic send_temperature(logic [TEMP_W-1:0] tk, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			temp_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		temp_valid <= 1'b1;
		temperature_k <= tk;
		expected_rgb.push_back(blackbody_rgb(tk));
		do @(posedge clk); while (temp_stall);
		beats_sent++;
	endtask

	task automatic release_source();
		temp_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		rgb_t got, exp_v;
		if (arst_n && rgb_valid && !rgb_stall) begin
			got = '{red, green, blue};
			if (expected_rgb.size() == 0) begin
				unexpected_count++;
				if (mismatch_count + unexpected_count <= 10)
					$display("unexpected beat %h %h %h", red, green, blue);
			end else begin
				exp_v = expected_rgb.pop_front();
				beats_checked++;
				if (got !== exp_v) begin
					mismatch_count++;
					if (mismatch_count + unexpected_count <= 10)
						$display("mismatch: exp %h %h %h got %h %h %h", exp_v.red,
							exp_v.green, exp_v.blue, red, green, blue);
				end
			end
		end
	end

	// sink stall: random short and long gaps, a long hold-off when requested, or none when gaps are off
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			rgb_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else if (sink_idle > 0) begin
			rgb_stall <= 1'b1;
			sink_idle <= sink_idle - 1;
		end else if (sink_gaps_on) begin
			rgb_stall <= ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) == 0) sink_idle <= $urandom_range(8, 40);
		end else
			rgb_stall <= 1'b0;
	end

	task automatic test_directed();
		logic [TEMP_W-1:0] pts[] = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1499,
			16'd1500, 16'd2500, 16'd4000, 16'd6500, 16'd6503, 16'd7777, 16'd9499,
			16'd9500, 16'd9999, 16'd10000, 16'd10001, 16'd32768, 16'd65535,
			16'h5555, 16'h2AAA};
		foreach (pts[i]) send_temperature(pts[i], 1'b0);
		release_source();
	endtask

	task automatic test_segment_sweep();
		for (int s = 0; s <= 9000; s += 250)
			send_temperature(16'(1000 + s), 1'b1);
		release_source();
	endtask

	task automatic test_random();
		logic [TEMP_W-1:0] tk;
		for (int i = 0; i < 1800; i++) begin
			case ($urandom_range(0, 9))
				0: tk = 16'($urandom_range(0, 65535));
				1: tk = 16'($urandom_range(0, 1000));
				default: tk = 16'($urandom_range(1000, 10000));
			endcase
			send_temperature(tk, $urandom_range(0, 3) != 0);
		end
		release_source();
	endtask

	task automatic test_back_pressure();
		hold_off_cycles = 200;
		for (int i = 0; i < 60; i++)
			send_temperature(16'($urandom_range(900, 10100)), 1'b0);
		release_source();
	endtask

	task automatic test_full_rate();
		sink_gaps_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_temperature(16'($urandom), 1'b0);
		release_source();
		sink_gaps_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_segment_sweep();
		test_back_pressure();
		test_full_rate();
		test_random();
		while (expected_rgb.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d temperature beats, checked %0d RGB beats", beats_sent, beats_checked);
		$display("covered clamps, segment edges, back-pressure hold-off and random gaps");
		if (mismatch_count == 0 && unexpected_count == 0 && expected_rgb.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ctr_pkg.sv
rtl/ctr_front.sv
rtl/ctr_spline.sv
rtl/ctr_norm.sv
rtl/color_temperature_to_rgb.sv
tb/tb_top.sv
